### hdl/serial_frame_receiver_crc16_defines.svh
// Assertion macros shared by the serial frame receiver RTL.
`ifndef SERIAL_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_CRC16_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define SFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define SFR_ASSERT(label, prop, msg)
`define SFR_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### hdl/sfrcrc_pkg.sv
// Types, constants and the CRC byte update for the serial frame receiver.
package sfrcrc_pkg;

    // Receive phases of the frame state machine.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SOP    = 3'd1,
        PH_HDR    = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC_LO = 3'd4,
        PH_CRC_HI = 3'd5
    } t_phase;

    // End-of-frame event codes.
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_GOOD     = 2'd1,
        EV_CRC_ERR  = 2'd2,
        EV_LEN_ERR  = 2'd3
    } t_event;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_OFF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_OFF = 2'd2;

    localparam int unsigned HDR_LEN_W = 7;
    localparam int unsigned OFFSET_W  = 6;
    localparam int unsigned CFG_DATA_W = 7;

    localparam logic [HDR_LEN_W-1:0] HDR_LEN_RST  = 7'd16;
    localparam logic [OFFSET_W-1:0]  LEN_OFF_RST  = 6'd15;
    localparam logic [OFFSET_W-1:0]  CTL_OFF_RST  = 6'd13;

    localparam logic [7:0]  SOF_BYTE0 = 8'hAA;
    localparam logic [7:0]  SOF_BYTE1 = 8'h55;
    localparam logic [7:0]  BYTE_MAX  = 8'hFF;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam int unsigned ACK_BIT   = 7;

    localparam int unsigned COUNT_W = 32;
    localparam int unsigned TDATA_W = 88;
    localparam int unsigned TUSER_W = 3;

    // CRC-16/CCITT-FALSE update by one byte, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // CRC after the start pair, fixed at elaboration.
    localparam logic [15:0] CRC_SOP = crc16_byte(crc16_byte(CRC_INIT, SOF_BYTE0), SOF_BYTE1);

endpackage

### hdl/serial_frame_receiver_crc16.sv
// Framed serial byte receiver with start-pair hunt, length tracking and CRC-16 check.
//
//  Channel   Direction  Request carries
//  s_axis    in         one received serial byte
//  m_axis    out        echoed byte, end-of-frame event, length, ack flag, frame counts
//  cfg       in         register index and write data
//
// Every accepted byte produces exactly one result request, in the cycle after acceptance.
// A byte is accepted in every cycle while the output register is empty or being drained,
// so the sustained rate is one byte per cycle; the CRC and frame-state update is combinational
// on the accepted byte and is registered together with the output register.
// Reset is synchronous and active low; it returns the receiver to hunting for 0xAA and
// restores the configuration registers to their defaults. A stall on m_axis holds the
// output register and drops s_axis_tready until the pending result is taken.
`include "serial_frame_receiver_crc16_defines.svh"

module serial_frame_receiver_crc16 #(
    parameter int unsigned MAX_FRAME = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]                         s_axis_tdata,

    output logic                               o_m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] frame_byte, [15:8] frame_length, [16] is_ack, [48:17] good_count,
    // [80:49] error_count, [87:81] zero
    output logic [sfrcrc_pkg::TDATA_W-1:0]     o_m_axis_tdata,
    // [0] frame_byte_valid, [2:1] event_res
    output logic [sfrcrc_pkg::TUSER_W-1:0]     o_m_axis_tuser,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sfrcrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfrcrc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sfrcrc_pkg::*;

    // The byte counter must hold MAX_FRAME itself; compares run at a width that
    // also holds the 8-bit length byte.
    localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
    localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;

    // Configuration registers.
    logic [HDR_LEN_W-1:0] r_hdr_len;
    logic [OFFSET_W-1:0]  r_len_off;
    logic [OFFSET_W-1:0]  r_ctl_off;

    // Frame state.
    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [15:0]          r_crc, n_crc;
    logic [7:0]           r_len_val, n_len_val;
    logic                 r_len_seen, n_len_seen;
    logic [7:0]           r_ctl_val, n_ctl_val;
    logic [7:0]           r_crc_lo, n_crc_lo;
    logic [COUNT_W-1:0]   r_good, n_good;
    logic [COUNT_W-1:0]   r_err, n_err;

    // Output register.
    logic                 r_m_valid;
    logic [TDATA_W-1:0]   r_m_data;
    logic [TUSER_W-1:0]   r_m_user;

    logic                 s_acc;
    logic [7:0]           rx;

    // Shared conditions for a header or body byte.
    logic [CNT_W-1:0]     w_cnt_inc;
    logic                 w_len_hit;
    logic                 w_ctl_hit;
    logic [7:0]           w_len_nx;
    logic                 w_seen_nx;
    logic [7:0]           w_ctl_nx;
    logic                 w_len_done;
    logic                 w_len_err;
    logic                 w_hdr_done;
    logic                 w_crc_match;

    // Result of the current byte.
    logic                 res_valid;
    t_event               res_event;
    logic [7:0]           res_flen;
    logic                 res_ack;

    assign rx              = s_axis_tdata;
    assign o_s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_acc           = s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    // The length and control bytes are captured before completion is judged, so a
    // length byte that arrives now already counts against the incremented count.
    assign w_cnt_inc  = r_cnt + 1'b1;
    assign w_len_hit  = CMP_W'(r_cnt) == CMP_W'(r_len_off);
    assign w_ctl_hit  = CMP_W'(r_cnt) == CMP_W'(r_ctl_off);
    assign w_len_nx   = w_len_hit ? rx : r_len_val;
    assign w_seen_nx  = r_len_seen || w_len_hit;
    assign w_ctl_nx   = w_ctl_hit ? rx : r_ctl_val;
    assign w_hdr_done = CMP_W'(w_cnt_inc) == CMP_W'(r_hdr_len);
    assign w_len_done = w_seen_nx && (CMP_W'(w_cnt_inc) == CMP_W'(w_len_nx));
    assign w_len_err  = (w_seen_nx && (CMP_W'(w_cnt_inc) > CMP_W'(w_len_nx)))
                     || (CMP_W'(w_cnt_inc) >= CMP_W'(MAX_FRAME));
    assign w_crc_match = {rx, r_crc_lo} == r_crc;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                if (rx == SOF_BYTE0) begin
                    n_phase = PH_SOP;
                end
            end
            PH_SOP: begin
                n_phase = (rx == SOF_BYTE1) ? PH_HDR : PH_IDLE;
            end
            PH_HDR, PH_DATA: begin
                if (r_phase == PH_HDR && w_hdr_done) begin
                    n_phase = PH_DATA;
                end
                if (w_len_done) begin
                    n_phase = PH_CRC_LO;
                end else if (w_len_err) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CRC_LO: n_phase = PH_CRC_HI;
            PH_CRC_HI: n_phase = PH_IDLE;
            default:   n_phase = PH_IDLE;
        endcase
    end

    // Datapath and result of the current byte.
    always_comb begin
        n_cnt      = r_cnt;
        n_crc      = r_crc;
        n_len_val  = r_len_val;
        n_len_seen = r_len_seen;
        n_ctl_val  = r_ctl_val;
        n_crc_lo   = r_crc_lo;
        n_good     = r_good;
        n_err      = r_err;
        res_valid  = 1'b0;
        res_event  = EV_NONE;
        res_flen   = 8'd0;
        res_ack    = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
            end
            PH_SOP: begin
                if (rx == SOF_BYTE1) begin
                    n_crc      = CRC_SOP;
                    n_cnt      = CNT_W'(2);
                    n_len_val  = 8'd0;
                    n_len_seen = 1'b0;
                    n_ctl_val  = 8'd0;
                    res_valid  = 1'b1;
                end
            end
            PH_HDR, PH_DATA: begin
                res_valid  = 1'b1;
                n_crc      = crc16_byte(r_crc, rx);
                n_len_val  = w_len_nx;
                n_len_seen = w_seen_nx;
                n_ctl_val  = w_ctl_nx;
                n_cnt      = w_cnt_inc;
                if (!w_len_done && w_len_err) begin
                    res_event = EV_LEN_ERR;
                    res_flen  = (CMP_W'(w_cnt_inc) > CMP_W'(BYTE_MAX)) ? BYTE_MAX
                                                                      : 8'(w_cnt_inc);
                    res_ack   = w_ctl_nx[ACK_BIT];
                    n_err     = r_err + 1'b1;
                end
            end
            PH_CRC_LO: begin
                n_crc_lo = rx;
            end
            PH_CRC_HI: begin
                if (w_crc_match) begin
                    res_event = EV_GOOD;
                    n_good    = r_good + 1'b1;
                end else begin
                    res_event = EV_CRC_ERR;
                    n_err     = r_err + 1'b1;
                end
                res_flen = (CMP_W'(r_cnt) > CMP_W'(BYTE_MAX)) ? BYTE_MAX : 8'(r_cnt);
                res_ack  = r_ctl_val[ACK_BIT];
            end
            default: begin
            end
        endcase
    end

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_len <= HDR_LEN_RST;
            r_len_off <= LEN_OFF_RST;
            r_ctl_off <= CTL_OFF_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER_LEN:  r_hdr_len <= i_cfg_data;
                CFG_LENGTH_OFF:  r_len_off <= i_cfg_data[OFFSET_W-1:0];
                CFG_CONTROL_OFF: r_ctl_off <= i_cfg_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Frame state advances once per accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_cnt      <= '0;
            r_crc      <= CRC_INIT;
            r_len_val  <= 8'd0;
            r_len_seen <= 1'b0;
            r_ctl_val  <= 8'd0;
            r_crc_lo   <= 8'd0;
            r_good     <= '0;
            r_err      <= '0;
        end else if (s_acc) begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_crc      <= n_crc;
            r_len_val  <= n_len_val;
            r_len_seen <= n_len_seen;
            r_ctl_val  <= n_ctl_val;
            r_crc_lo   <= n_crc_lo;
            r_good     <= n_good;
            r_err      <= n_err;
        end
    end

    // Output register: loaded on accept, emptied when the sink takes the request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_acc) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_m_data <= {7'd0, n_err, n_good, res_ack, res_flen,
                         (res_valid ? rx : 8'd0)};
            r_m_user <= {res_event, res_valid};
        end
    end

    // A CRC-checked frame end is never reported on a stored byte.
    `SFR_ASSERT(a_crc_event_not_data, (r_m_valid && (r_m_user[2:1] == EV_GOOD || r_m_user[2:1] == EV_CRC_ERR)) |-> !r_m_user[0], "CRC event on a data byte")
    // The CRC bytes are only reached once the length byte was captured.
    `SFR_ASSERT(a_crc_needs_length, (r_phase == PH_CRC_LO || r_phase == PH_CRC_HI) |-> r_len_seen, "CRC phase without a length byte")
    // The byte counter never runs past the frame limit.
    `SFR_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(MAX_FRAME), "byte count beyond frame limit")
    // Each stored byte advances the counter by exactly one.
    `SFR_ASSERT(a_cnt_step, (s_acc && (r_phase == PH_HDR || r_phase == PH_DATA)) |=> (r_cnt == $past(r_cnt) + 1'b1), "byte count did not advance")
    // The error count moves only on an accepted byte.
    `SFR_ASSERT(a_err_on_accept, (r_err != $past(r_err)) |-> $past(s_acc), "error count changed without a byte")

endmodule
